[hw/rtl/porl_pkg.sv]
// Shared types and constants for the per-origin call rate limiter.
// No dependencies; imported by every module of the block.
package porl_pkg;

  localparam int TIME_BITS   = 32;
  localparam int MIN_BITS    = 27;
  localparam int BAN_BITS    = 33;
  localparam int LIM_BITS    = 16;
  localparam int LEN_BITS    = 32;
  localparam int ORIGIN_BITS = 8;
  localparam int METHOD_BITS = 4;
  localparam int KIND_BITS   = 2;

  // Divide a 32-bit time by 60: multiply by reciprocal, keep bits above the shift
  localparam logic [31:0] DIV60_MUL   = 32'h8888_8889;
  localparam int          DIV60_SHIFT = 37;

  typedef enum logic [2:0] {
    V_OK         = 3'd0,
    V_BAD_ORIGIN = 3'd1,
    V_BANNED     = 3'd2,
    V_BAN_MIN    = 3'd3,
    V_BAN_SEC    = 3'd4
  } verdict_e;

  // Class of a call as seen by the front end
  typedef enum logic [KIND_BITS-1:0] {
    K_PASS  = 2'd0,
    K_BAD   = 2'd1,
    K_TRACK = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_ENABLE       = 3'd0,
    REG_ORG_MAX_SEC  = 3'd1,
    REG_ORG_MAX_MIN  = 3'd2,
    REG_ORG_BAN_SEC  = 3'd3,
    REG_ORG_BAN_MIN  = 3'd4,
    REG_GLB_MAX_SEC  = 3'd5,
    REG_GLB_MAX_MIN  = 3'd6,
    REG_GLB_BAN      = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic                enabled;
    logic [LIM_BITS-1:0] org_max_s;
    logic [LIM_BITS-1:0] org_max_m;
    logic [LEN_BITS-1:0] org_ban_s;
    logic [LEN_BITS-1:0] org_ban_m;
    logic [LIM_BITS-1:0] glb_max_s;
    logic [LIM_BITS-1:0] glb_max_m;
    logic [LEN_BITS-1:0] glb_ban;
  } cfg_t;

endpackage

[hw/rtl/porl_front.sv]
// Front end: classifies a call, folds its indices and derives its minute.
// Depends on porl_pkg.
module porl_front import porl_pkg::*; #(
  parameter int ORIGIN_SLOTS = 256,
  parameter int METHOD_SLOTS = 16,
  localparam int OB = $clog2(ORIGIN_SLOTS),
  localparam int MB = (METHOD_SLOTS > 1) ? $clog2(METHOD_SLOTS) : 1
) (
  input  logic                 enabled_i,
  input  logic [ORIGIN_BITS-1:0] origin_id_i,
  input  logic [METHOD_BITS-1:0] method_id_i,
  input  logic [TIME_BITS-1:0] call_time_i,
  output kind_e                kind_o,
  output logic [OB-1:0]        oidx_o,
  output logic [MB-1:0]        midx_o,
  output logic [MIN_BITS-1:0]  minute_o
);

  localparam int OTAB = 1 << ORIGIN_BITS;
  localparam int MTAB = 1 << METHOD_BITS;

  logic [OB-1:0] otab [OTAB];
  logic [MB-1:0] mtab [MTAB];
  logic [63:0]   prod;

  // Fold indices by constant tables
  for (genvar i = 0; i < OTAB; i++) begin : g_otab
    assign otab[i] = OB'(i % ORIGIN_SLOTS);
  end
  for (genvar i = 0; i < MTAB; i++) begin : g_mtab
    assign mtab[i] = MB'(i % METHOD_SLOTS);
  end

  assign oidx_o = otab[origin_id_i];
  assign midx_o = mtab[method_id_i];

  // Minute by reciprocal multiply
  assign prod     = 64'(call_time_i) * 64'(DIV60_MUL);
  assign minute_o = prod[DIV60_SHIFT+MIN_BITS-1:DIV60_SHIFT];

  // Classify
  always_comb begin
    if (!enabled_i) begin
      kind_o = K_PASS;
    end else if (origin_id_i == '0) begin
      kind_o = K_BAD;
    end else begin
      kind_o = K_TRACK;
    end
  end

endmodule

[hw/rtl/porl_queue.sv]
// Two-entry queue between front end and back end.
// Depends on porl_pkg for style only; generic payload width.
module porl_queue import porl_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] din_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] dout_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wp_q, wp_d, rp_q, rp_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign dout_o  = mem_q[rp_q];

  // Advance pointers and count
  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= din_i;
    end
  end

endmodule

[hw/rtl/porl_back.sv]
// Back end: global and per-origin trackers, origin row memory, result register.
// Depends on porl_pkg.
module porl_back import porl_pkg::*; #(
  parameter int ORIGIN_SLOTS = 256,
  parameter int METHOD_SLOTS = 16,
  parameter int COUNT_BITS   = 16,
  localparam int OB = $clog2(ORIGIN_SLOTS),
  localparam int MB = (METHOD_SLOTS > 1) ? $clog2(METHOD_SLOTS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  input  kind_e               kind_i,
  input  logic [OB-1:0]       oidx_i,
  input  logic [MB-1:0]       midx_i,
  input  logic [TIME_BITS-1:0] time_i,
  input  logic [MIN_BITS-1:0] minute_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output verdict_e            verdict_o,
  output logic                by_global_o
);

  localparam int CB = COUNT_BITS;
  localparam int VB = METHOD_SLOTS * CB;
  localparam int RW = TIME_BITS + MIN_BITS + BAN_BITS + 2 * VB;

  typedef enum logic {S_READ, S_EXEC} state_e;

  typedef struct packed {
    logic                adv_s;
    logic                adv_m;
    logic [CB-1:0]       cnt_s;
    logic [CB-1:0]       cnt_m;
    verdict_e            v;
    logic                ban_set;
    logic [BAN_BITS-1:0] ban_end;
  } trk_t;

  // One tracker step for the addressed method
  function automatic trk_t track_f(
    input logic [TIME_BITS-1:0] t,
    input logic [MIN_BITS-1:0]  mn,
    input logic [TIME_BITS-1:0] w_s,
    input logic [MIN_BITS-1:0]  w_m,
    input logic [BAN_BITS-1:0]  be,
    input logic [CB-1:0]        cs,
    input logic [CB-1:0]        cm,
    input logic [LIM_BITS-1:0]  mx_s,
    input logic [LIM_BITS-1:0]  mx_m,
    input logic [LEN_BITS-1:0]  bl_s,
    input logic [LEN_BITS-1:0]  bl_m
  );
    trk_t                r;
    logic [CB-1:0]       bs;
    logic [CB-1:0]       bm;
    logic [BAN_BITS-1:0] tx;
    r.adv_s   = t > w_s;
    r.adv_m   = mn > w_m;
    bs        = r.adv_s ? '0 : cs;
    bm        = r.adv_m ? '0 : cm;
    r.cnt_s   = (&bs) ? bs : bs + CB'(1);
    r.cnt_m   = (&bm) ? bm : bm + CB'(1);
    tx        = BAN_BITS'(t);
    r.ban_set = 1'b0;
    r.ban_end = be;
    r.v       = V_OK;
    if (tx <= be) begin
      r.v = V_BANNED;
    end else if (mx_m != '0 && 32'(r.cnt_m) > 32'(mx_m)) begin
      r.v       = V_BAN_MIN;
      r.ban_set = 1'b1;
      r.ban_end = tx + BAN_BITS'(bl_m);
    end else if (mx_s != '0 && 32'(r.cnt_s) > 32'(mx_s)) begin
      r.v       = V_BAN_SEC;
      r.ban_set = 1'b1;
      r.ban_end = tx + BAN_BITS'(bl_s);
    end
    return r;
  endfunction

  state_e              state_q;
  logic                out_vld_q;
  verdict_e            verdict_q;
  logic                by_glb_q;

  logic [TIME_BITS-1:0] g_sec_q;
  logic [MIN_BITS-1:0]  g_min_q;
  logic [BAN_BITS-1:0]  g_ban_q;
  logic [CB-1:0]        g_cs_q [METHOD_SLOTS];
  logic [CB-1:0]        g_cm_q [METHOD_SLOTS];
  logic [CB-1:0]        g_cs_d [METHOD_SLOTS];
  logic [CB-1:0]        g_cm_d [METHOD_SLOTS];
  logic                 known_q [ORIGIN_SLOTS];

  logic [RW-1:0]        row_mem [ORIGIN_SLOTS];
  logic [RW-1:0]        row_q;

  kind_e                it_kind_q;
  logic [OB-1:0]        it_oidx_q;
  logic [MB-1:0]        it_midx_q;
  logic [TIME_BITS-1:0] it_t_q;
  logic [MIN_BITS-1:0]  it_min_q;

  logic                 fire;
  trk_t                 g_r, o_r;
  logic [TIME_BITS-1:0] r_sec;
  logic [MIN_BITS-1:0]  r_min;
  logic [BAN_BITS-1:0]  r_ban;
  logic [VB-1:0]        r_cs, r_cm, n_cs, n_cm;
  logic [RW-1:0]        wr_row;
  logic                 wr_en, g_upd, known_set;
  verdict_e             verdict_d;
  logic                 by_glb_d;

  assign q_pop_o     = (state_q == S_READ) && !q_empty_i;
  assign fire        = (state_q == S_EXEC) && (!out_vld_q || !out_stall_i);
  assign out_valid_o = out_vld_q;
  assign verdict_o   = verdict_q;
  assign by_global_o = by_glb_q;

  // Unpack the origin row
  assign r_sec = row_q[RW-1 -: TIME_BITS];
  assign r_min = row_q[RW-TIME_BITS-1 -: MIN_BITS];
  assign r_ban = row_q[RW-TIME_BITS-MIN_BITS-1 -: BAN_BITS];
  assign r_cm  = row_q[2*VB-1:VB];
  assign r_cs  = row_q[VB-1:0];

  // Run both trackers
  always_comb begin
    g_r = track_f(it_t_q, it_min_q, g_sec_q, g_min_q, g_ban_q,
                  g_cs_q[it_midx_q], g_cm_q[it_midx_q],
                  cfg_i.glb_max_s, cfg_i.glb_max_m, cfg_i.glb_ban, cfg_i.glb_ban);
    o_r = track_f(it_t_q, it_min_q, r_sec, r_min, r_ban,
                  r_cs[it_midx_q*CB +: CB], r_cm[it_midx_q*CB +: CB],
                  cfg_i.org_max_s, cfg_i.org_max_m, cfg_i.org_ban_s, cfg_i.org_ban_m);
  end

  // Next global counts: clear on window advance, then count the method
  always_comb begin
    for (int i = 0; i < METHOD_SLOTS; i++) begin
      g_cs_d[i] = g_r.adv_s ? '0 : g_cs_q[i];
      g_cm_d[i] = g_r.adv_m ? '0 : g_cm_q[i];
    end
    g_cs_d[it_midx_q] = g_r.cnt_s;
    g_cm_d[it_midx_q] = g_r.cnt_m;
  end

  // Decide verdict and write-back
  always_comb begin
    n_cs = o_r.adv_s ? '0 : r_cs;
    n_cm = o_r.adv_m ? '0 : r_cm;
    n_cs[it_midx_q*CB +: CB] = o_r.cnt_s;
    n_cm[it_midx_q*CB +: CB] = o_r.cnt_m;
    wr_row    = {(o_r.adv_s ? it_t_q : r_sec), (o_r.adv_m ? it_min_q : r_min),
                 o_r.ban_end, n_cm, n_cs};
    wr_en     = 1'b0;
    g_upd     = 1'b0;
    known_set = 1'b0;
    verdict_d = V_OK;
    by_glb_d  = 1'b0;
    case (it_kind_q)
      K_PASS: verdict_d = V_OK;
      K_BAD:  verdict_d = V_BAD_ORIGIN;
      K_TRACK: begin
        g_upd = 1'b1;
        if (g_r.v != V_OK) begin
          verdict_d = g_r.v;
          by_glb_d  = 1'b1;
        end else if (!known_q[it_oidx_q]) begin
          known_set = 1'b1;
          wr_en     = 1'b1;
          wr_row    = {it_t_q, it_min_q, {BAN_BITS{1'b0}}, {(2*VB){1'b0}}};
        end else begin
          wr_en     = 1'b1;
          verdict_d = o_r.v;
        end
      end
      default: verdict_d = V_OK;
    endcase
  end

  // Sequencer, result register, global state and origin valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_READ;
      out_vld_q <= 1'b0;
      verdict_q <= V_OK;
      by_glb_q  <= 1'b0;
      g_sec_q   <= '0;
      g_min_q   <= '0;
      g_ban_q   <= '0;
      for (int i = 0; i < METHOD_SLOTS; i++) begin
        g_cs_q[i] <= '0;
        g_cm_q[i] <= '0;
      end
      for (int i = 0; i < ORIGIN_SLOTS; i++) begin
        known_q[i] <= 1'b0;
      end
    end else begin
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_READ: begin
          if (!q_empty_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state_q   <= S_READ;
            verdict_q <= verdict_d;
            by_glb_q  <= by_glb_d;
          end
        end
        default: state_q <= S_READ;
      endcase
      if (fire && g_upd) begin
        if (g_r.adv_s) begin
          g_sec_q <= it_t_q;
        end
        if (g_r.adv_m) begin
          g_min_q <= it_min_q;
        end
        for (int i = 0; i < METHOD_SLOTS; i++) begin
          g_cs_q[i] <= g_cs_d[i];
          g_cm_q[i] <= g_cm_d[i];
        end
        if (g_r.ban_set) begin
          g_ban_q <= g_r.ban_end;
        end
      end
      if (fire && known_set) begin
        known_q[it_oidx_q] <= 1'b1;
      end
    end
  end

  // Latch the item, read and write the origin row
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      it_kind_q <= kind_i;
      it_oidx_q <= oidx_i;
      it_midx_q <= midx_i;
      it_t_q    <= time_i;
      it_min_q  <= minute_i;
      row_q     <= row_mem[oidx_i];
    end
    if (fire && wr_en) begin
      row_mem[it_oidx_q] <= wr_row;
    end
  end

endmodule

[hw/rtl/per_origin_call_rate_limiter_unit.sv]
// Per-origin call rate limiter. The back end sequencer reads the origin row memory (one
// read port, one write port) in S_READ and writes it back in S_EXEC, so it takes a new
// call only after the last one is through; S_EXEC waits while a held result is stalled.
// Reset: limiter enabled, other registers zero, global windows and counts cleared,
// all origins unknown; no clearing pass, calls accepted right after reset.
module per_origin_call_rate_limiter_unit import porl_pkg::*; #(
  parameter int ORIGIN_SLOTS = 256,
  parameter int METHOD_SLOTS = 16,
  parameter int COUNT_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ORIGIN_BITS-1:0] origin_id_i,
  input  logic [METHOD_BITS-1:0] method_id_i,
  input  logic [TIME_BITS-1:0]   call_time_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             verdict_o,
  output logic                   by_global_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  localparam int OB = $clog2(ORIGIN_SLOTS);
  localparam int MB = (METHOD_SLOTS > 1) ? $clog2(METHOD_SLOTS) : 1;
  localparam int QW = KIND_BITS + OB + MB + TIME_BITS + MIN_BITS;

  cfg_t                 cfg_q;
  kind_e                f_kind;
  logic [OB-1:0]        f_oidx;
  logic [MB-1:0]        f_midx;
  logic [MIN_BITS-1:0]  f_min;
  logic                 q_full, q_empty, q_pop, q_push;
  logic [QW-1:0]        q_din, q_dout;
  verdict_e             b_verdict;

  // Configuration registers; enable is the top bit of the record
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= {1'b1, {($bits(cfg_t)-1){1'b0}}};
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_ENABLE:      cfg_q.enabled   <= cfg_data_i[0];
        REG_ORG_MAX_SEC: cfg_q.org_max_s <= cfg_data_i[LIM_BITS-1:0];
        REG_ORG_MAX_MIN: cfg_q.org_max_m <= cfg_data_i[LIM_BITS-1:0];
        REG_ORG_BAN_SEC: cfg_q.org_ban_s <= cfg_data_i;
        REG_ORG_BAN_MIN: cfg_q.org_ban_m <= cfg_data_i;
        REG_GLB_MAX_SEC: cfg_q.glb_max_s <= cfg_data_i[LIM_BITS-1:0];
        REG_GLB_MAX_MIN: cfg_q.glb_max_m <= cfg_data_i[LIM_BITS-1:0];
        REG_GLB_BAN:     cfg_q.glb_ban   <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  porl_front #(
    .ORIGIN_SLOTS(ORIGIN_SLOTS),
    .METHOD_SLOTS(METHOD_SLOTS)
  ) u_front (
    .enabled_i  (cfg_q.enabled),
    .origin_id_i(origin_id_i),
    .method_id_i(method_id_i),
    .call_time_i(call_time_i),
    .kind_o     (f_kind),
    .oidx_o     (f_oidx),
    .midx_o     (f_midx),
    .minute_o   (f_min)
  );

  // Enqueue classified transactions
  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;
  assign q_din      = {f_kind, f_oidx, f_midx, call_time_i, f_min};

  porl_queue #(.W(QW)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .din_i  (q_din),
    .full_o (q_full),
    .pop_i  (q_pop),
    .dout_o (q_dout),
    .empty_o(q_empty)
  );

  porl_back #(
    .ORIGIN_SLOTS(ORIGIN_SLOTS),
    .METHOD_SLOTS(METHOD_SLOTS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .kind_i     (kind_e'(q_dout[QW-1 -: KIND_BITS])),
    .oidx_i     (q_dout[QW-KIND_BITS-1 -: OB]),
    .midx_i     (q_dout[QW-KIND_BITS-OB-1 -: MB]),
    .time_i     (q_dout[TIME_BITS+MIN_BITS-1:MIN_BITS]),
    .minute_i   (q_dout[MIN_BITS-1:0]),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .verdict_o  (b_verdict),
    .by_global_o(by_global_o)
  );

  assign verdict_o = b_verdict;

  // A global flag only goes with a nonzero verdict
  a_glb_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && by_global_o |-> b_verdict != V_OK)
    else $error("global flag with no-error verdict");

  // A bad origin never comes from the global tracker
  a_bad_local: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && b_verdict == V_BAD_ORIGIN |-> !by_global_o)
    else $error("bad origin flagged as global");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

[sim/per_origin_call_rate_limiter_unit_test.sv]
// Self-checking testbench for the per-origin call rate limiter unit.
// Drives a directed table and constrained-free random calls, predicts every verdict in
// step with the block, and compares it. Depends on porl_pkg and the unit.
`timescale 1ns / 100ps

module per_origin_call_rate_limiter_unit_test;
  import porl_pkg::*;

  localparam int MAX_CYCLES = 400000;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct {
    logic [7:0]  origin;
    logic [3:0]  method;
    logic [31:0] t;
    logic        has_exp;
    verdict_e    exp_v;
    logic        exp_g;
  } call_row_t;

  typedef struct {
    verdict_e v;
    logic     g;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  origin_id_i = '0;
  logic [3:0]  method_id_i = '0;
  logic [31:0] call_time_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  verdict_o;
  logic        by_global_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  per_origin_call_rate_limiter_unit i_dut (.*);

  // Predictor state
  logic        p_en;
  logic [15:0] p_omax_s, p_omax_m, p_gmax_s, p_gmax_m;
  logic [31:0] p_oban_s, p_oban_m, p_gban;
  logic [31:0] g_sec;
  logic [26:0] g_min;
  logic [32:0] g_ban;
  logic [15:0] g_scnt [16];
  logic [15:0] g_mcnt [16];
  logic        o_known [256];
  logic [31:0] o_sec [256];
  logic [26:0] o_min [256];
  logic [32:0] o_ban [256];
  logic [15:0] o_scnt [256][16];
  logic [15:0] o_mcnt [256][16];

  verdict_t    pending_verdicts[$];
  int          errors = 0;
  int          calls_sent = 0;
  int          verdicts_seen = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  call_row_t   directed[$];

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] sat_inc(logic [15:0] c);
    return (c == CNT_MAX) ? c : c + 16'd1;
  endfunction

  // Advance one window tracker and return its verdict
  task automatic run_tracker(inout logic [31:0] sec, inout logic [26:0] mnt,
                             inout logic [32:0] ban, inout logic [15:0] scnt [16],
                             inout logic [15:0] mcnt [16], input logic [3:0] m,
                             input logic [31:0] t, input logic [15:0] max_s,
                             input logic [15:0] max_m, input logic [31:0] ban_s,
                             input logic [31:0] ban_m, output verdict_e v);
    logic [26:0] tm;
    tm = 27'(t / 60);
    if (t > sec) begin
      foreach (scnt[i]) scnt[i] = '0;
      sec = t;
    end
    if (tm > mnt) begin
      foreach (mcnt[i]) mcnt[i] = '0;
      mnt = tm;
    end
    scnt[m] = sat_inc(scnt[m]);
    mcnt[m] = sat_inc(mcnt[m]);
    if ({1'b0, t} <= ban) v = V_BANNED;
    else if (max_m != 0 && mcnt[m] > max_m) begin
      ban = {1'b0, t} + {1'b0, ban_m};
      v = V_BAN_MIN;
    end else if (max_s != 0 && scnt[m] > max_s) begin
      ban = {1'b0, t} + {1'b0, ban_s};
      v = V_BAN_SEC;
    end else v = V_OK;
  endtask

  // Compute the verdict of one call and update the predictor
  task automatic predict_verdict(input logic [7:0] o, input logic [3:0] m,
                                 input logic [31:0] t, output verdict_t r);
    logic [15:0] sc [16];
    logic [15:0] mc [16];
    verdict_e v;
    r.v = V_OK;
    r.g = 1'b0;
    if (!p_en) return;
    if (o == 0) begin
      r.v = V_BAD_ORIGIN;
      return;
    end
    run_tracker(g_sec, g_min, g_ban, g_scnt, g_mcnt, m, t, p_gmax_s, p_gmax_m,
                p_gban, p_gban, v);
    if (v != V_OK) begin
      r.v = v;
      r.g = 1'b1;
      return;
    end
    if (!o_known[o]) begin
      o_known[o] = 1'b1;
      o_sec[o] = t;
      o_min[o] = 27'(t / 60);
      o_ban[o] = '0;
      for (int i = 0; i < 16; i++) begin
        o_scnt[o][i] = '0;
        o_mcnt[o][i] = '0;
      end
      return;
    end
    sc = o_scnt[o];
    mc = o_mcnt[o];
    run_tracker(o_sec[o], o_min[o], o_ban[o], sc, mc, m, t, p_omax_s, p_omax_m,
                p_oban_s, p_oban_m, v);
    o_scnt[o] = sc;
    o_mcnt[o] = mc;
    r.v = v;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
             verdicts_seen);
    errors++;
  endtask

  // Receiver: random stall, compare accepted verdicts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        verdicts_seen++;
        if (pending_verdicts.size() == 0) begin
          report_mismatch("waiting calls", 0, 1);
        end else begin
          verdict_t w;
          w = pending_verdicts.pop_front();
          if (verdict_o != w.v) report_mismatch("verdict", verdict_o, w.v);
          if (by_global_o != w.g) report_mismatch("by_global", by_global_o, w.g);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Drive one call; expectation is queued when the transaction is accepted.
  // Valid stays up afterwards so the next call can follow; drain drops it.
  task automatic send_call(input logic [7:0] o, input logic [3:0] m, input logic [31:0] t,
                           input logic has_exp, input verdict_e ev, input logic eg);
    verdict_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    origin_id_i <= o;
    method_id_i <= m;
    call_time_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_verdict(o, m, t, r);
    if (has_exp) begin
      if (r.v != ev) report_mismatch("table verdict vs predictor", r.v, ev);
      if (r.g != eg) report_mismatch("table by_global vs predictor", r.g, eg);
      r.v = ev;
      r.g = eg;
    end
    pending_verdicts = {pending_verdicts, r};
    calls_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Write one register while idle
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_ENABLE:      p_en = val[0];
      REG_ORG_MAX_SEC: p_omax_s = val[15:0];
      REG_ORG_MAX_MIN: p_omax_m = val[15:0];
      REG_ORG_BAN_SEC: p_oban_s = val;
      REG_ORG_BAN_MIN: p_oban_m = val;
      REG_GLB_MAX_SEC: p_gmax_s = val[15:0];
      REG_GLB_MAX_MIN: p_gmax_m = val[15:0];
      REG_GLB_BAN:     p_gban = val;
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [7:0] o, input logic [3:0] m, input logic [31:0] t,
                         input logic he, input verdict_e v, input logic g);
    call_row_t row;
    row.origin = o; row.method = m; row.t = t; row.has_exp = he;
    row.exp_v = v; row.exp_g = g;
    directed = {directed, row};
  endtask

  // One random phase: limits, ban lengths and a burst of calls
  task automatic random_phase(input int n_calls, input logic [15:0] lim_s,
                              input logic [15:0] lim_m, input logic [31:0] ban_len);
    logic [31:0] now;
    write_reg(REG_ORG_MAX_SEC, lim_s);
    write_reg(REG_ORG_MAX_MIN, lim_m);
    write_reg(REG_ORG_BAN_SEC, ban_len);
    write_reg(REG_ORG_BAN_MIN, ban_len + 32'($urandom_range(3)));
    write_reg(REG_GLB_MAX_SEC, lim_s == 0 ? 16'd0 : lim_s + 16'd3);
    write_reg(REG_GLB_MAX_MIN, lim_m == 0 ? 16'd0 : lim_m + 16'd5);
    write_reg(REG_GLB_BAN, 32'($urandom_range(2)));
    now = $urandom_range(1000, 5000);
    for (int i = 0; i < n_calls; i++) begin
      logic [31:0] t;
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) now = now + ($urandom_range(9) < 6 ? 0 : $urandom_range(1, 70));
      if (pick < 85) t = now;
      else if (pick < 92) t = now - $urandom_range(5);
      else t = $urandom();
      send_call(($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(1, 6)),
                ($urandom_range(3) == 0) ? 4'($urandom()) : 4'($urandom_range(1)),
                t, 1'b0, V_OK, 1'b0);
      now = (pick >= 92) ? now : now;
    end
  endtask

  initial begin
    p_en = 1'b1;
    {p_omax_s, p_omax_m, p_gmax_s, p_gmax_m} = '0;
    {p_oban_s, p_oban_m, p_gban} = '0;
    g_sec = '0; g_min = '0; g_ban = '0;
    foreach (g_scnt[i]) begin
      g_scnt[i] = '0;
      g_mcnt[i] = '0;
    end
    foreach (o_known[i]) o_known[i] = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: reset values, ban end zero, empty origin, extremes
    add_row(8'd5, 4'd0, 32'd0, 1'b1, V_BANNED, 1'b1);
    add_row(8'd0, 4'd3, 32'd7, 1'b1, V_BAD_ORIGIN, 1'b0);
    add_row(8'd255, 4'd15, 32'hFFFF_FFFF, 1'b1, V_OK, 1'b0);
    add_row(8'd255, 4'd15, 32'hFFFF_FFFF, 1'b1, V_OK, 1'b0);
    add_row(8'd1, 4'd0, 32'd100, 1'b1, V_OK, 1'b0);
    foreach (directed[i])
      send_call(directed[i].origin, directed[i].method, directed[i].t,
                directed[i].has_exp, directed[i].exp_v, directed[i].exp_g);
    drain();

    // Tight origin limits: second ban, already banned, time going back
    write_reg(REG_ORG_MAX_SEC, 16'd2);
    write_reg(REG_ORG_MAX_MIN, 16'd4);
    write_reg(REG_ORG_BAN_SEC, 32'd3);
    write_reg(REG_ORG_BAN_MIN, 32'hFFFF_FFFF);
    directed.delete();
    add_row(8'd2, 4'd1, 32'd200, 1'b1, V_OK, 1'b0);
    for (int i = 0; i < 3; i++) add_row(8'd2, 4'd1, 32'd201, 1'b0, V_OK, 1'b0);
    add_row(8'd2, 4'd1, 32'd202, 1'b0, V_OK, 1'b0);
    add_row(8'd2, 4'd1, 32'd199, 1'b0, V_OK, 1'b0);
    add_row(8'd3, 4'd2, 32'd300, 1'b0, V_OK, 1'b0);
    for (int i = 0; i < 4; i++) add_row(8'd3, 4'd2, 32'd361 + i, 1'b0, V_OK, 1'b0);
    foreach (directed[i])
      send_call(directed[i].origin, directed[i].method, directed[i].t,
                directed[i].has_exp, directed[i].exp_v, directed[i].exp_g);
    drain();

    // Global limits at extremes, then disabled
    write_reg(REG_GLB_MAX_SEC, 16'd1);
    write_reg(REG_GLB_MAX_MIN, 16'hFFFF);
    write_reg(REG_GLB_BAN, 32'd50);
    send_call(8'd4, 4'd9, 32'd1000, 1'b0, V_OK, 1'b0);
    send_call(8'd4, 4'd9, 32'd1000, 1'b1, V_BAN_SEC, 1'b1);
    send_call(8'd6, 4'd9, 32'd1020, 1'b1, V_BANNED, 1'b1);
    drain();
    write_reg(REG_ENABLE, 32'd0);
    send_call(8'd0, 4'd0, 32'd0, 1'b1, V_OK, 1'b0);
    send_call(8'd9, 4'd1, 32'd5, 1'b1, V_OK, 1'b0);
    drain();
    write_reg(REG_ENABLE, 32'hFFFF_FFFF);
    write_reg(REG_GLB_BAN, 32'd0);
    write_reg(REG_GLB_MAX_SEC, 16'd0);
    write_reg(REG_GLB_MAX_MIN, 16'd0);
    // The global ban ended at 1050, so a later call from a fresh origin passes
    send_call(8'd7, 4'd0, 32'd3000, 1'b1, V_OK, 1'b0);
    drain();

    // Random part over three idle profiles
    send_idle_pct = 19; recv_idle_pct = 48;
    random_phase(130, 16'd3, 16'd8, 32'd2);
    drain();
    send_idle_pct = 48; recv_idle_pct = 19;
    random_phase(130, 16'hFFFF, 16'd1, 32'hFFFF_FFFF);
    // Hold off until every verdict is in
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(130, 16'd0, 16'd0, 32'd0);
    drain();

    $display("covered %0d calls and %0d verdicts across directed, banned and random phases",
             calls_sent, verdicts_seen);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/porl_pkg.sv
hw/rtl/porl_front.sv
hw/rtl/porl_queue.sv
hw/rtl/porl_back.sv
hw/rtl/per_origin_call_rate_limiter_unit.sv
sim/per_origin_call_rate_limiter_unit_test.sv
